@@ rtl/owtr_pkg.sv @@
`timescale 1ns / 1ps

package owtr_pkg;

    localparam int TICK_W  = 20;
    localparam int SPAN_W  = TICK_W + 1;
    localparam int CFG_W   = 20;
    localparam int SHORT_W = 16;
    localparam int RAW_W   = 16;
    localparam int CENTI_W = 19;

    localparam logic [CENTI_W-1:0] CENTI_MAX = 19'd409600;

    // register indexes on the write port
    localparam logic [2:0] CFG_IDLE_RELEASE  = 3'd0;
    localparam logic [2:0] CFG_RESET_LOW     = 3'd1;
    localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd2;
    localparam logic [2:0] CFG_SLOT          = 3'd3;
    localparam logic [2:0] CFG_CONVERT_WAIT  = 3'd4;

    // bus commands, and the sign mask for the high byte
    localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
    localparam logic [7:0] CMD_CONVERT      = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;
    localparam logic [7:0] SIGN_MASK        = 8'hF8;

    typedef enum logic [19:0] {
        PH_IDLE      = 20'd1 << 0,
        PH_RELEASE1  = 20'd1 << 1,
        PH_RST_LOW1  = 20'd1 << 2,
        PH_PRESENCE1 = 20'd1 << 3,
        PH_REC_PRES1 = 20'd1 << 4,
        PH_WR_SKIP1  = 20'd1 << 5,
        PH_REC_SKIP1 = 20'd1 << 6,
        PH_WR_CONV   = 20'd1 << 7,
        PH_REC_CONV  = 20'd1 << 8,
        PH_CONV_WAIT = 20'd1 << 9,
        PH_RELEASE2  = 20'd1 << 10,
        PH_RST_LOW2  = 20'd1 << 11,
        PH_PRESENCE2 = 20'd1 << 12,
        PH_REC_PRES2 = 20'd1 << 13,
        PH_WR_SKIP2  = 20'd1 << 14,
        PH_REC_SKIP2 = 20'd1 << 15,
        PH_WR_READ   = 20'd1 << 16,
        PH_REC_READ  = 20'd1 << 17,
        PH_RD_LOW    = 20'd1 << 18,
        PH_RD_HIGH   = 20'd1 << 19
    } phase_t;

    typedef struct packed {
        logic             drive_low;
        logic             busy_res;
        logic             result_valid;
        logic [RAW_W-1:0] raw_word;
    } step_res_t;

    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               result_valid;
        logic [RAW_W-1:0]   raw_word;
        logic               is_negative;
        logic [CENTI_W-1:0] centi_degrees;
    } out_item_t;

    function automatic phase_t next_phase(input phase_t ph);
        phase_t nx;
        case (ph)
            PH_RELEASE1:  nx = PH_RST_LOW1;
            PH_RST_LOW1:  nx = PH_PRESENCE1;
            PH_PRESENCE1: nx = PH_REC_PRES1;
            PH_REC_PRES1: nx = PH_WR_SKIP1;
            PH_WR_SKIP1:  nx = PH_REC_SKIP1;
            PH_REC_SKIP1: nx = PH_WR_CONV;
            PH_WR_CONV:   nx = PH_REC_CONV;
            PH_REC_CONV:  nx = PH_CONV_WAIT;
            PH_CONV_WAIT: nx = PH_RELEASE2;
            PH_RELEASE2:  nx = PH_RST_LOW2;
            PH_RST_LOW2:  nx = PH_PRESENCE2;
            PH_PRESENCE2: nx = PH_REC_PRES2;
            PH_REC_PRES2: nx = PH_WR_SKIP2;
            PH_WR_SKIP2:  nx = PH_REC_SKIP2;
            PH_REC_SKIP2: nx = PH_WR_READ;
            PH_WR_READ:   nx = PH_REC_READ;
            PH_REC_READ:  nx = PH_RD_LOW;
            PH_RD_LOW:    nx = PH_RD_HIGH;
            default:      nx = PH_IDLE;
        endcase
        return nx;
    endfunction

    function automatic logic [7:0] write_byte(input phase_t ph);
        logic [7:0] b;
        case (ph)
            PH_WR_SKIP1: b = CMD_SKIP_ROM;
            PH_WR_SKIP2: b = CMD_SKIP_ROM;
            PH_WR_CONV:  b = CMD_CONVERT;
            PH_WR_READ:  b = CMD_READ_SCRATCH;
            default:     b = 8'h00;
        endcase
        return b;
    endfunction

    // a zero tick count acts as one
    function automatic logic [SPAN_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? SPAN_W'(1) : SPAN_W'(v);
    endfunction

endpackage

@@ rtl/owtr_seq.sv @@
`timescale 1ns / 1ps

module owtr_seq
    import owtr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                step_en,
    input  logic                start_req,
    input  logic                bus_level,
    output step_res_t           step_res
);

    logic [SHORT_W-1:0] idle_rel_reg, rst_low_reg, pres_wait_reg, slot_reg;
    logic [TICK_W-1:0]  conv_wait_reg;

    phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [2:0]         bit_reg, bit_next;
    logic [7:0]         shift_reg, shift_next;
    logic [7:0]         low_reg, low_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;

    logic               drive, busy, valid, done, span_end, in_slot, reading;
    logic [SPAN_W-1:0]  span_len;
    logic [7:0]         wbyte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_rel_reg  <= SHORT_W'(8);
            rst_low_reg   <= SHORT_W'(80);
            pres_wait_reg <= SHORT_W'(10);
            slot_reg      <= SHORT_W'(5);
            conv_wait_reg <= TICK_W'(100);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDLE_RELEASE:  idle_rel_reg  <= cfg_data[SHORT_W-1:0];
                CFG_RESET_LOW:     rst_low_reg   <= cfg_data[SHORT_W-1:0];
                CFG_PRESENCE_WAIT: pres_wait_reg <= cfg_data[SHORT_W-1:0];
                CFG_SLOT:          slot_reg      <= cfg_data[SHORT_W-1:0];
                CFG_CONVERT_WAIT:  conv_wait_reg <= cfg_data[TICK_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        low_next   = low_reg;
        raw_next   = raw_reg;
        drive      = 1'b0;
        valid      = 1'b0;
        done       = 1'b0;

        if (phase_reg == PH_IDLE && start_req)
        begin
            phase_next = PH_RELEASE1;
            tick_next  = '0;
            bit_next   = '0;
        end

        busy    = (phase_next != PH_IDLE);
        reading = (phase_next == PH_RD_LOW) || (phase_next == PH_RD_HIGH);
        in_slot = reading || (phase_next == PH_WR_SKIP1) || (phase_next == PH_WR_CONV)
                  || (phase_next == PH_WR_SKIP2) || (phase_next == PH_WR_READ);
        wbyte   = write_byte(phase_next);

        case (phase_next)
            PH_RELEASE1, PH_RELEASE2:   span_len = at_least_one(TICK_W'(idle_rel_reg));
            PH_RST_LOW1, PH_RST_LOW2:   span_len = at_least_one(TICK_W'(rst_low_reg));
            PH_PRESENCE1, PH_PRESENCE2: span_len = at_least_one(TICK_W'(pres_wait_reg));
            PH_CONV_WAIT:               span_len = at_least_one(conv_wait_reg);
            default:
            begin
                // bit slots are one tick longer than the recovery spans
                if (in_slot)
                    span_len = at_least_one(TICK_W'(slot_reg)) + SPAN_W'(1);
                else
                    span_len = at_least_one(TICK_W'(slot_reg));
            end
        endcase

        span_end = ({1'b0, tick_next} + SPAN_W'(1)) >= span_len;

        if (phase_next == PH_RST_LOW1 || phase_next == PH_RST_LOW2)
            drive = 1'b1;
        else if (in_slot)
        begin
            if (tick_next == '0)
                drive = 1'b1;
            else if (reading)
            begin
                if (tick_next == TICK_W'(1))
                    shift_next = {bus_level, shift_reg[7:1]};
            end
            else
                drive = ~wbyte[bit_next];
        end

        if (busy)
        begin
            if (in_slot)
            begin
                if (span_end)
                begin
                    if (bit_next == 3'd7)
                    begin
                        done = 1'b1;
                        if (phase_next == PH_RD_LOW)
                            low_next = shift_next;
                        else if (phase_next == PH_RD_HIGH)
                        begin
                            raw_next = {shift_next, low_reg};
                            valid    = 1'b1;
                        end
                    end
                    else
                        bit_next = bit_next + 3'd1;
                end
            end
            else
                done = span_end;

            tick_next = span_end ? '0 : tick_next + TICK_W'(1);

            if (done)
            begin
                tick_next  = '0;
                bit_next   = '0;
                phase_next = next_phase(phase_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            low_reg   <= '0;
            raw_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            low_reg   <= low_next;
            raw_reg   <= raw_next;
        end
    end

    assign step_res.drive_low    = drive;
    assign step_res.busy_res     = busy;
    assign step_res.result_valid = valid;
    assign step_res.raw_word     = raw_next;

endmodule

@@ rtl/owtr_conv.sv @@
`timescale 1ns / 1ps

module owtr_conv
    import owtr_pkg::*;
(
    input  logic [RAW_W-1:0]   raw_word,
    output logic               is_negative,
    output logic [CENTI_W-1:0] centi_degrees
);

    logic [RAW_W:0]   mag;
    logic [RAW_W+5:0] scaled;
    logic [RAW_W+3:0] quarter;

    always_comb
    begin
        is_negative = (raw_word[15:8] & SIGN_MASK) == SIGN_MASK;
        mag = is_negative ? (17'h10000 - {1'b0, raw_word}) : {1'b0, raw_word};
        // mag * 25 + 2, then divide by four: 6.25 per lsb, half up
        scaled  = {mag, 4'b0} + {1'b0, mag, 3'b0} + (RAW_W+6)'(mag) + (RAW_W+6)'(2);
        quarter = scaled[RAW_W+5:2];
        if (quarter > (RAW_W+4)'(CENTI_MAX))
            centi_degrees = CENTI_MAX;
        else
            centi_degrees = quarter[CENTI_W-1:0];
    end

endmodule

@@ rtl/owtr_outq.sv @@
`timescale 1ns / 1ps

module owtr_outq
    import owtr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      full,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    out_item_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop       = out_valid && !out_stall;
    assign out_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/onewire_temperature_reader_unit.sv @@
`timescale 1ns / 1ps

// one-wire master that reads a temperature sensor, one bus tick per request
// input channel: in_valid / in_stall with start_req and bus_level; each
//   request is one timing tick of the bus, sampled level included
// output channel: out_valid / out_stall; every input request gives exactly
//   one output request carrying drive_low, busy_res, result_valid and the
//   last completed reading (raw_word, is_negative, centi_degrees)
// config: cfg_we / cfg_index / cfg_data write the five tick-count registers
//   at any edge with cfg_we high; write them only while the block is idle
// path: a tick is held in the input register, then the sequencer step
//   writes its result into the output queue, which raises out_valid
// throughput: one request per cycle while the output queue has room; the
//   sequencer step is a single pass of short logic, and a two-entry output
//   queue lets a new tick come in while a finished one waits to be taken
// stall: in_stall rises only when the output queue is full and the input
//   register holds a tick; nothing is dropped or repeated
// reset: sequencer idle, tick registers back to their defaults, held
//   reading zero, input register and output queue empty

module onewire_temperature_reader_unit
    import owtr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               start_req,
    input  logic               bus_level,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               drive_low,
    output logic               busy_res,
    output logic               result_valid,
    output logic [RAW_W-1:0]   raw_word,
    output logic               is_negative,
    output logic [CENTI_W-1:0] centi_degrees
);

    // input register
    logic      s1_valid_reg, s1_valid_next;
    logic      s1_start_reg, s1_bus_reg;
    logic      in_take, step_fire, q_full;

    step_res_t step_res;
    out_item_t step_item, q_item;
    logic      conv_neg;
    logic [CENTI_W-1:0] conv_centi;

    assign in_stall  = s1_valid_reg && q_full;
    assign in_take   = in_valid && !in_stall;
    // the sequencer advances one tick whenever the input register holds a tick and the queue has room
    assign step_fire = s1_valid_reg && !q_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (step_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_start_reg <= start_req;
            s1_bus_reg   <= bus_level;
        end
    end

    // bus sequencer: phases, tick and bit counters, byte shifter
    owtr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (step_fire),
        .start_req (s1_start_reg),
        .bus_level (s1_bus_reg),
        .step_res  (step_res)
    );

    // raw word to sign and hundredths of a degree
    owtr_conv u_conv (
        .raw_word      (step_res.raw_word),
        .is_negative   (conv_neg),
        .centi_degrees (conv_centi)
    );

    always_comb
    begin
        step_item.drive_low     = step_res.drive_low;
        step_item.busy_res      = step_res.busy_res;
        step_item.result_valid  = step_res.result_valid;
        step_item.raw_word      = step_res.raw_word;
        step_item.is_negative   = conv_neg;
        step_item.centi_degrees = conv_centi;
    end

    // two-entry output queue decouples the receiver's stall
    owtr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_fire),
        .push_item (step_item),
        .full      (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (q_item)
    );

    assign drive_low     = q_item.drive_low;
    assign busy_res      = q_item.busy_res;
    assign result_valid  = q_item.result_valid;
    assign raw_word      = q_item.raw_word;
    assign is_negative   = q_item.is_negative;
    assign centi_degrees = q_item.centi_degrees;

    // a finished reading only appears inside a running sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_valid |-> busy_res)
        else $error("result_valid outside a read sequence");

    // the line is never pulled low while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_low |-> busy_res)
        else $error("drive_low while idle");

    // sign flag agrees with the raw word it came from
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_negative == (raw_word[15:11] == 5'h1f))
        else $error("sign flag disagrees with raw word");

    // a stalled input tick is held until the sequencer takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !step_fire && !in_take |=> s1_valid_reg)
        else $error("input tick lost");

endmodule
